### rtl/pkdf_pkg.sv
package pkdf_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	localparam logic [1:0] MODE_PW    = 2'd0;
	localparam logic [1:0] MODE_SALT  = 2'd1;
	localparam logic [1:0] MODE_START = 2'd2;

	localparam logic [7:0] IPAD_BYTE = 8'h36;
	localparam logic [7:0] OPAD_BYTE = 8'h5C;
	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [6:0] MAX_KEY_BYTES = 7'd64;

	localparam logic [0:0] REG_ITER   = 1'b0;
	localparam logic [0:0] REG_KEYLEN = 1'b1;

	localparam logic [255:0] SHA_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_KICK,
		ST_COMP,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		OP_KEYHASH,
		OP_IPAD,
		OP_OPAD,
		OP_INNER_SALT,
		OP_OUTER,
		OP_INNER_CHAIN
	} op_t;

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
			32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
			32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
			32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
			32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
			32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
			32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
			32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
			32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[idx];
	endfunction

endpackage

### rtl/pkdf_front.sv
module pkdf_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      mode,
	input  logic [7:0]      data_byte,
	output logic            busy,
	output logic            q_valid,
	output pkdf_pkg::item_t q_item,
	input  logic            q_pop
);

	pkdf_pkg::item_t         mem_q [pkdf_pkg::QDEPTH];
	logic [pkdf_pkg::QAW-1:0] wr_q, rd_q;
	logic [pkdf_pkg::QAW:0]   cnt_q;
	logic                     push;
	logic                     do_pop;

	assign busy    = (cnt_q == (pkdf_pkg::QAW+1)'(pkdf_pkg::QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item  = mem_q[rd_q];

	// The unused mode code is accepted and then dropped here.
	assign push   = start && !busy && (mode == pkdf_pkg::MODE_PW ||
		mode == pkdf_pkg::MODE_SALT || mode == pkdf_pkg::MODE_START);
	assign do_pop = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{mode: mode, data: data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (pkdf_pkg::QAW+1)'(push) - (pkdf_pkg::QAW+1)'(do_pop);
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (pkdf_pkg::QAW+1)'(pkdf_pkg::QDEPTH))
		else $error("queue count beyond depth");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !push) |=> cnt_q == $past(cnt_q) - (pkdf_pkg::QAW+1)'($past(q_valid)))
		else $error("pop did not drain the queue");
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !q_pop) |=> busy)
		else $error("queue lost entries while full");

endmodule

### rtl/pkdf_sha_core.sv
module pkdf_sha_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [255:0] state_in,
	input  logic [511:0] block_in,
	output logic         done,
	output logic [255:0] state_out
);

	logic [31:0]  v_q [8];
	logic [31:0]  w_q [16];
	logic [255:0] st_q;
	logic [6:0]   rnd_q;
	logic         run_q;
	logic         done_q;
	logic [255:0] out_q;
	logic [31:0]  e1, ch, t1, a0, mj, s0, s1, w_new;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	always_comb begin
		e1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + e1 + ch + pkdf_pkg::round_k(rnd_q[5:0]) + w_q[0];
		a0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
	end

	always_ff @(posedge clk) begin
		if (go) begin
			st_q <= state_in;
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= state_in[255-32*i -: 32];
			end
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= block_in[511-32*i -: 32];
			end
		end else if (run_q && !rnd_q[6]) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + a0 + mj;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
		if (run_q && rnd_q[6]) begin
			for (int i = 0; i < 8; i++) begin
				out_q[255-32*i -: 32] <= st_q[255-32*i -: 32] + v_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && rnd_q[6];
			if (go) begin
				rnd_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (rnd_q[6]) begin
					run_q <= 1'b0;
				end else begin
					rnd_q <= rnd_q + 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign state_out = out_q;

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> !run_q)
		else $error("compression started while running");
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(run_q) && !run_q)
		else $error("done without a finished run");
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_q <= 7'd64)
		else $error("round counter out of range");

endmodule

### rtl/pkdf_back.sv
module pkdf_back #(
	parameter int MAX_PASSWORD_BYTES = 128,
	parameter int MAX_SALT_BYTES = 124
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  pkdf_pkg::item_t q_item,
	output logic            q_pop,
	input  logic [31:0]     iteration_count,
	input  logic [6:0]      key_length,
	output logic [7:0]      key_byte,
	output logic            key_valid,
	output logic            last,
	output logic            overflow
);

	localparam int PAW = (MAX_PASSWORD_BYTES > 1) ? $clog2(MAX_PASSWORD_BYTES) : 1;
	localparam int PCW = $clog2(MAX_PASSWORD_BYTES + 1);
	localparam int SDEPTH = (MAX_SALT_BYTES > 0) ? MAX_SALT_BYTES : 1;
	localparam int SAW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
	localparam int SCW = (MAX_SALT_BYTES > 0) ? $clog2(MAX_SALT_BYTES + 1) : 1;
	localparam int ML1 = (MAX_PASSWORD_BYTES > MAX_SALT_BYTES + 4) ?
		MAX_PASSWORD_BYTES : MAX_SALT_BYTES + 4;
	localparam int MAXLEN = (ML1 > 64) ? ML1 : 64;
	localparam int LW = $clog2(MAXLEN + 1);
	localparam int POS_W = $clog2(MAXLEN + 73);
	localparam int BLK_W = POS_W - 6;
	localparam int BL_W = $clog2((MAXLEN + 64) * 8 + 1);

	logic [7:0] pw_mem [MAX_PASSWORD_BYTES];
	logic [7:0] salt_mem [SDEPTH];
	logic [7:0] pw_rd_q, salt_rd_q;

	pkdf_pkg::state_t state_q, state_d;
	pkdf_pkg::op_t    op_q, launch_op;
	logic             launch;
	logic [BLK_W-1:0] blk_idx_q;
	logic [6:0]       cnt_q;
	logic             v_s1;
	logic [5:0]       cnt_s1;
	logic [POS_W-1:0] gpos_s1;
	logic [511:0]     blk_q;
	logic [255:0]     hst_q, dig_q, key_q, inner_q, outer_q, acc_q;
	logic             key_long_q, first_q;
	logic [31:0]      iter_left_q;
	logic [1:0]       bnum_q;
	logic [6:0]       kl_q, emitted_q;
	logic [4:0]       ebyte_q;
	logic             ovf_q;
	logic [PCW-1:0]   pcount_q;
	logic [SCW-1:0]   scount_q;
	logic             drop_q;
	logic [7:0]       key_byte_q;
	logic             key_valid_q, last_q, overflow_q;

	logic             core_go, core_done;
	logic [255:0]     core_out;
	logic [LW-1:0]    len_c;
	logic [POS_W-1:0] nb_c, gpos_c, kdiff, lenp8;
	logic [BL_W-1:0]  bitlen;
	logic [63:0]      bits64;
	logic [7:0]       src_byte, fill_byte, kb;
	logic             is_pad, op_fin, emit_end, clear_stores;
	logic [6:0]       kl_in;
	logic             load_pw, load_salt, take_start;
	logic [255:0]     start_state;

	pkdf_sha_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (core_go),
		.state_in (hst_q),
		.block_in (blk_q),
		.done     (core_done),
		.state_out(core_out)
	);

	// Message length, block count and position within the padded message.
	always_comb begin
		is_pad = (op_q == pkdf_pkg::OP_IPAD) || (op_q == pkdf_pkg::OP_OPAD);
		case (op_q)
			pkdf_pkg::OP_KEYHASH:    len_c = LW'(pcount_q);
			pkdf_pkg::OP_INNER_SALT: len_c = LW'(scount_q) + LW'(4);
			pkdf_pkg::OP_OUTER,
			pkdf_pkg::OP_INNER_CHAIN: len_c = LW'(32);
			default:                 len_c = LW'(64);
		endcase
		lenp8 = POS_W'(len_c) + POS_W'(8);
		nb_c = is_pad ? POS_W'(1) : (lenp8 >> 6) + POS_W'(1);
		gpos_c = {blk_idx_q, cnt_q[5:0]};
		bitlen = (BL_W'(len_c) + ((op_q == pkdf_pkg::OP_KEYHASH) ? BL_W'(0) : BL_W'(64)))
			<< 3;
		bits64 = 64'(bitlen);
		kdiff = (nb_c << 6) - POS_W'(1) - gpos_s1;
	end

	// Byte of the block under construction, one stage after the store read.
	always_comb begin
		case (op_q)
			pkdf_pkg::OP_KEYHASH: src_byte = pw_rd_q;
			pkdf_pkg::OP_INNER_SALT: begin
				if (gpos_s1 < POS_W'(scount_q)) begin
					src_byte = salt_rd_q;
				end else if (gpos_s1 == POS_W'(scount_q) + POS_W'(3)) begin
					src_byte = {6'd0, bnum_q};
				end else begin
					src_byte = 8'd0;
				end
			end
			default: src_byte = dig_q[8*(5'd31 - gpos_s1[4:0]) +: 8];
		endcase
		if (key_long_q) begin
			kb = cnt_s1[5] ? 8'd0 : key_q[8*(5'd31 - cnt_s1[4:0]) +: 8];
		end else begin
			kb = (PCW'(cnt_s1) < pcount_q) ? pw_rd_q : 8'd0;
		end
		if (is_pad) begin
			fill_byte = kb ^ ((op_q == pkdf_pkg::OP_IPAD) ?
				pkdf_pkg::IPAD_BYTE : pkdf_pkg::OPAD_BYTE);
		end else if (gpos_s1 < POS_W'(len_c)) begin
			fill_byte = src_byte;
		end else if (gpos_s1 == POS_W'(len_c)) begin
			fill_byte = pkdf_pkg::PAD_MARK;
		end else if (kdiff < POS_W'(8)) begin
			fill_byte = bits64[{kdiff[2:0], 3'b000} +: 8];
		end else begin
			fill_byte = 8'd0;
		end
	end

	always_comb begin
		kl_in = (key_length > pkdf_pkg::MAX_KEY_BYTES) ? pkdf_pkg::MAX_KEY_BYTES : key_length;
		load_pw = (state_q == pkdf_pkg::ST_IDLE) && q_valid &&
			(q_item.mode == pkdf_pkg::MODE_PW);
		load_salt = (state_q == pkdf_pkg::ST_IDLE) && q_valid &&
			(q_item.mode == pkdf_pkg::MODE_SALT);
		take_start = (state_q == pkdf_pkg::ST_IDLE) && q_valid &&
			(q_item.mode == pkdf_pkg::MODE_START);
		op_fin = (state_q == pkdf_pkg::ST_COMP) && core_done &&
			(POS_W'(blk_idx_q) + POS_W'(1) >= nb_c);
		emit_end = (state_q == pkdf_pkg::ST_EMIT) &&
			((emitted_q + 7'd1 == kl_q) || (ebyte_q == 5'd31));
		launch = 1'b0;
		launch_op = pkdf_pkg::OP_IPAD;
		if (take_start && kl_in != 7'd0) begin
			launch = 1'b1;
			launch_op = (pcount_q > PCW'(64)) ? pkdf_pkg::OP_KEYHASH : pkdf_pkg::OP_IPAD;
		end else if (op_fin) begin
			case (op_q)
				pkdf_pkg::OP_KEYHASH: begin
					launch = 1'b1;
					launch_op = pkdf_pkg::OP_IPAD;
				end
				pkdf_pkg::OP_IPAD: begin
					launch = 1'b1;
					launch_op = pkdf_pkg::OP_OPAD;
				end
				pkdf_pkg::OP_OPAD: begin
					launch = 1'b1;
					launch_op = pkdf_pkg::OP_INNER_SALT;
				end
				pkdf_pkg::OP_OUTER: begin
					launch = (iter_left_q > 32'd1);
					launch_op = pkdf_pkg::OP_INNER_CHAIN;
				end
				default: begin
					launch = 1'b1;
					launch_op = pkdf_pkg::OP_OUTER;
				end
			endcase
		end else if (emit_end && (emitted_q + 7'd1 != kl_q)) begin
			launch = 1'b1;
			launch_op = pkdf_pkg::OP_INNER_SALT;
		end
		clear_stores = (take_start && kl_in == 7'd0) ||
			(emit_end && (emitted_q + 7'd1 == kl_q));
		case (launch_op)
			pkdf_pkg::OP_INNER_SALT,
			pkdf_pkg::OP_INNER_CHAIN: start_state = inner_q;
			pkdf_pkg::OP_OUTER:       start_state = outer_q;
			default:                  start_state = pkdf_pkg::SHA_IV;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pkdf_pkg::ST_IDLE: begin
				if (launch) begin
					state_d = pkdf_pkg::ST_FILL;
				end
			end
			pkdf_pkg::ST_FILL: begin
				if (v_s1 && cnt_s1 == 6'd63) begin
					state_d = pkdf_pkg::ST_KICK;
				end
			end
			pkdf_pkg::ST_KICK: state_d = pkdf_pkg::ST_COMP;
			pkdf_pkg::ST_COMP: begin
				if (core_done) begin
					if (!op_fin || launch) begin
						state_d = pkdf_pkg::ST_FILL;
					end else begin
						state_d = pkdf_pkg::ST_EMIT;
					end
				end
			end
			pkdf_pkg::ST_EMIT: begin
				if (emit_end) begin
					state_d = launch ? pkdf_pkg::ST_FILL : pkdf_pkg::ST_IDLE;
				end
			end
			default: state_d = pkdf_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		q_pop = (state_q == pkdf_pkg::ST_IDLE) && q_valid;
		core_go = (state_q == pkdf_pkg::ST_KICK);
	end

	always_ff @(posedge clk) begin
		if (load_pw && pcount_q < PCW'(MAX_PASSWORD_BYTES)) begin
			pw_mem[pcount_q[PAW-1:0]] <= q_item.data;
		end
		if (load_salt && scount_q < SCW'(MAX_SALT_BYTES)) begin
			salt_mem[scount_q[SAW-1:0]] <= q_item.data;
		end
		pw_rd_q <= pw_mem[gpos_c[PAW-1:0]];
		salt_rd_q <= salt_mem[gpos_c[SAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == pkdf_pkg::ST_FILL && v_s1) begin
			blk_q <= {blk_q[503:0], fill_byte};
		end
		if (launch) begin
			hst_q <= start_state;
		end else if (state_q == pkdf_pkg::ST_COMP && core_done) begin
			hst_q <= core_out;
		end
		if (op_fin) begin
			case (op_q)
				pkdf_pkg::OP_KEYHASH: key_q <= core_out;
				pkdf_pkg::OP_IPAD:    inner_q <= core_out;
				pkdf_pkg::OP_OPAD:    outer_q <= core_out;
				pkdf_pkg::OP_OUTER: begin
					dig_q <= core_out;
					acc_q <= first_q ? core_out : (acc_q ^ core_out);
				end
				default: dig_q <= core_out;
			endcase
		end
		if (launch && launch_op == pkdf_pkg::OP_INNER_SALT) begin
			iter_left_q <= (iteration_count == 32'd0) ? 32'd1 : iteration_count;
		end else if (op_fin && op_q == pkdf_pkg::OP_OUTER) begin
			iter_left_q <= iter_left_q - 32'd1;
		end
		if (take_start) begin
			ovf_q <= drop_q;
			kl_q <= kl_in;
		end
		gpos_s1 <= gpos_c;
		cnt_s1 <= cnt_q[5:0];
		key_byte_q <= acc_q[8*(5'd31 - ebyte_q) +: 8];
		last_q <= (emitted_q + 7'd1 == kl_q);
		overflow_q <= ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pkdf_pkg::ST_IDLE;
			op_q <= pkdf_pkg::OP_IPAD;
			blk_idx_q <= '0;
			cnt_q <= '0;
			v_s1 <= 1'b0;
			key_long_q <= 1'b0;
			first_q <= 1'b0;
			bnum_q <= 2'd1;
			emitted_q <= '0;
			ebyte_q <= '0;
			pcount_q <= '0;
			scount_q <= '0;
			drop_q <= 1'b0;
			key_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1 <= (state_q == pkdf_pkg::ST_FILL) && !cnt_q[6];
			if (state_q == pkdf_pkg::ST_FILL && !cnt_q[6]) begin
				cnt_q <= cnt_q + 7'd1;
			end
			if (launch) begin
				op_q <= launch_op;
				blk_idx_q <= '0;
				cnt_q <= '0;
				if (launch_op == pkdf_pkg::OP_INNER_SALT) begin
					first_q <= 1'b1;
				end else if (launch_op == pkdf_pkg::OP_INNER_CHAIN) begin
					first_q <= 1'b0;
				end
			end else if (state_q == pkdf_pkg::ST_COMP && core_done && !op_fin) begin
				blk_idx_q <= blk_idx_q + 1'b1;
				cnt_q <= '0;
			end
			if (op_fin && op_q == pkdf_pkg::OP_KEYHASH) begin
				key_long_q <= 1'b1;
			end
			if (take_start) begin
				bnum_q <= 2'd1;
				emitted_q <= '0;
				ebyte_q <= '0;
			end
			key_valid_q <= (state_q == pkdf_pkg::ST_EMIT);
			if (state_q == pkdf_pkg::ST_EMIT) begin
				emitted_q <= emitted_q + 7'd1;
				ebyte_q <= ebyte_q + 5'd1;
				if (emit_end) begin
					bnum_q <= 2'd2;
				end
			end
			if (load_pw) begin
				if (pcount_q < PCW'(MAX_PASSWORD_BYTES)) begin
					pcount_q <= pcount_q + 1'b1;
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (load_salt) begin
				if (scount_q < SCW'(MAX_SALT_BYTES)) begin
					scount_q <= scount_q + 1'b1;
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (clear_stores) begin
				pcount_q <= '0;
				scount_q <= '0;
				drop_q <= 1'b0;
				key_long_q <= 1'b0;
			end
		end
	end

	assign key_byte  = key_byte_q;
	assign key_valid = key_valid_q;
	assign last      = last_q;
	assign overflow  = overflow_q;

	a_valid_emit: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid_q |-> $past(state_q == pkdf_pkg::ST_EMIT))
		else $error("key byte without an emit cycle");
	a_pcount: assert property (@(posedge clk) disable iff (!arst_n)
		pcount_q <= PCW'(MAX_PASSWORD_BYTES))
		else $error("password count beyond capacity");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(key_valid_q && last_q) |-> state_q == pkdf_pkg::ST_IDLE)
		else $error("final byte sent while the derivation runs on");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == pkdf_pkg::ST_IDLE)
		else $error("queue read during a derivation");

endmodule

### rtl/pbkdf2_hmac_sha256_key_derive_unit.sv
// Channel   | Signals                                   | Direction
// command   | start, busy, mode, data_byte              | in (busy back)
// result    | key_valid, key_byte, last, overflow       | out
// config    | psel, penable, pwrite, paddr, pwdata,     | APB, pready tied high
//           | prdata, pready                            |
// Load bytes are taken one per cycle into a four-entry queue while it is not full,
// and the engine writes each into its store while idle. Each compression builds
// its block from the stores, launches in a kick state and runs in the core.
// A start costs up to five compressions for the key and pads, then per 32-byte
// block up to 2 * iterations + 2 compressions and an emit of up to 32 bytes.
// busy rises only when the queue is full; reset empties stores and queue.
module pbkdf2_hmac_sha256_key_derive_unit #(
	parameter int MAX_PASSWORD_BYTES = 128,
	parameter int MAX_SALT_BYTES = 124
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [7:0]  data_byte,
	output logic        key_valid,
	output logic [7:0]  key_byte,
	output logic        last,
	output logic        overflow,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0]     iter_q;
	logic [6:0]      keylen_q;
	logic            q_valid, q_pop;
	pkdf_pkg::item_t q_item;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == pkdf_pkg::REG_KEYLEN) ? {25'd0, keylen_q} : iter_q;

	// A configuration transaction lands in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= 32'd1000;
			keylen_q <= 7'd16;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == pkdf_pkg::REG_ITER) begin
				iter_q <= pwdata;
			end else begin
				keylen_q <= pwdata[6:0];
			end
		end
	end

	pkdf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.mode     (mode),
		.data_byte(data_byte),
		.busy     (busy),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	pkdf_back #(
		.MAX_PASSWORD_BYTES(MAX_PASSWORD_BYTES),
		.MAX_SALT_BYTES    (MAX_SALT_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop),
		.iteration_count(iter_q),
		.key_length     (keylen_q),
		.key_byte       (key_byte),
		.key_valid      (key_valid),
		.last           (last),
		.overflow       (overflow)
	);

endmodule

### verif/pbkdf2_hmac_sha256_key_derive_unit_tb.sv
`timescale 1ns / 1ps

module pbkdf2_hmac_sha256_key_derive_unit_tb;
	import pkdf_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int PW_CAP = 128;
	localparam int SALT_CAP = 124;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 1500;

	typedef struct {
		bit [7:0] key;
		bit       last;
		bit       ovf;
	} key_out_t;

	class pbkdf2_scoreboard;
		bit [31:0] iter_count = 32'd1000;
		bit [6:0]  key_len = 7'd16;
		bit [7:0]  pw_bytes[$];
		bit [7:0]  salt_bytes[$];
		bit        dropped;
		bit [31:0] inner_iv[8];
		bit [31:0] outer_iv[8];
		key_out_t  key_q[$];
		int        errors;
		int        checked;
		int        derivations;

		function bit [31:0] rotr(bit [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress(inout bit [31:0] st[8], input bit [7:0] blk[64]);
			bit [31:0] w[64];
			bit [31:0] v[8];
			bit [31:0] s0, s1, t1, t2;
			for (int t = 0; t < 16; t++)
				w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
			for (int t = 16; t < 64; t++) begin
				s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
				s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
				w[t] = w[t-16] + s0 + w[t-7] + s1;
			end
			v = st;
			for (int t = 0; t < 64; t++) begin
				t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
					((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(t[5:0]) + w[t];
				t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
					((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (int t = 0; t < 8; t++)
				st[t] += v[t];
		endfunction

		// Hashes msg as if prefix bytes were already folded into iv.
		function void sha_digest(input bit [31:0] iv[8], input int prefix,
				input bit [7:0] msg[$], output bit [7:0] dig[32]);
			bit [31:0] st[8];
			bit [7:0]  blk[64];
			bit [7:0]  tail[128];
			bit [63:0] nbits;
			int        pos, r, n;
			st = iv;
			pos = 0;
			nbits = 64'(prefix + msg.size()) * 8;
			while (msg.size() - pos >= 64) begin
				for (int i = 0; i < 64; i++)
					blk[i] = msg[pos+i];
				compress(st, blk);
				pos += 64;
			end
			r = msg.size() - pos;
			foreach (tail[i])
				tail[i] = 8'h00;
			for (int i = 0; i < r; i++)
				tail[i] = msg[pos+i];
			tail[r] = PAD_MARK;
			n = (r + 9 > 64) ? 128 : 64;
			for (int t = 0; t < 8; t++)
				tail[n-1-t] = nbits[8*t +: 8];
			for (int i = 0; i < 64; i++)
				blk[i] = tail[i];
			compress(st, blk);
			if (n == 128) begin
				for (int i = 0; i < 64; i++)
					blk[i] = tail[64+i];
				compress(st, blk);
			end
			for (int t = 0; t < 8; t++)
				{dig[4*t], dig[4*t+1], dig[4*t+2], dig[4*t+3]} = st[t];
		endfunction

		function void load_pads();
			bit [7:0]  k[64];
			bit [7:0]  dig[32];
			bit [7:0]  pad[64];
			bit [31:0] iv[8];
			for (int i = 0; i < 8; i++)
				iv[i] = SHA_IV[255-32*i -: 32];
			foreach (k[i])
				k[i] = 8'h00;
			if (pw_bytes.size() > 64) begin
				sha_digest(iv, 0, pw_bytes, dig);
				for (int i = 0; i < 32; i++)
					k[i] = dig[i];
			end else begin
				foreach (pw_bytes[i])
					k[i] = pw_bytes[i];
			end
			for (int i = 0; i < 64; i++)
				pad[i] = k[i] ^ IPAD_BYTE;
			inner_iv = iv;
			compress(inner_iv, pad);
			for (int i = 0; i < 64; i++)
				pad[i] = k[i] ^ OPAD_BYTE;
			outer_iv = iv;
			compress(outer_iv, pad);
		endfunction

		function void hmac(input bit [7:0] msg[$], output bit [7:0] mac[32]);
			bit [7:0] inner[32];
			bit [7:0] inner_q[$];
			sha_digest(inner_iv, 64, msg, inner);
			foreach (inner[i])
				inner_q.push_back(inner[i]);
			sha_digest(outer_iv, 64, inner_q, mac);
		endfunction

		function void derive_key();
			bit [7:0] msg[$];
			bit [7:0] u[32];
			bit [7:0] acc[32];
			int       kl, nblocks, emitted;
			key_out_t ko;
			kl = (key_len > MAX_KEY_BYTES) ? 64 : int'(key_len);
			nblocks = (kl + 31) / 32;
			emitted = 0;
			load_pads();
			for (int b = 1; b <= nblocks; b++) begin
				msg = salt_bytes;
				msg.push_back(8'(b >> 24));
				msg.push_back(8'(b >> 16));
				msg.push_back(8'(b >> 8));
				msg.push_back(8'(b));
				hmac(msg, u);
				acc = u;
				// An iteration count of zero runs the chain once, like one.
				for (longint j = 1; j < iter_count; j++) begin
					msg.delete();
					foreach (u[i])
						msg.push_back(u[i]);
					hmac(msg, u);
					foreach (acc[i])
						acc[i] ^= u[i];
				end
				for (int t = 0; t < 32 && emitted < kl; t++) begin
					ko.key = acc[t];
					ko.last = (emitted + 1 == kl);
					ko.ovf = dropped;
					key_q.push_back(ko);
					emitted++;
				end
			end
			pw_bytes.delete();
			salt_bytes.delete();
			dropped = 1'b0;
			derivations++;
		endfunction

		function void note_command(bit [1:0] md, bit [7:0] data);
			case (md)
				MODE_PW: begin
					if (pw_bytes.size() < PW_CAP)
						pw_bytes.push_back(data);
					else
						dropped = 1'b1;
				end
				MODE_SALT: begin
					if (salt_bytes.size() < SALT_CAP)
						salt_bytes.push_back(data);
					else
						dropped = 1'b1;
				end
				MODE_START: derive_key();
				default: ;
			endcase
		endfunction

		function void check_key(bit [7:0] key, bit lst, bit ovf);
			key_out_t exp_k;
			if (key_q.size() == 0) begin
				$error("key byte %0h with nothing outstanding", key);
				errors++;
				return;
			end
			exp_k = key_q.pop_front();
			checked++;
			if (key !== exp_k.key) begin
				$error("key_byte: expected %0h, got %0h", exp_k.key, key);
				errors++;
			end
			if (lst !== exp_k.last) begin
				$error("last: expected %0d, got %0d", exp_k.last, lst);
				errors++;
			end
			if (ovf !== exp_k.ovf) begin
				$error("overflow: expected %0d, got %0d", exp_k.ovf, ovf);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  mode = MODE_PW;
	logic [7:0]  data_byte = 8'h00;
	logic        key_valid;
	logic [7:0]  key_byte;
	logic        last;
	logic        overflow;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	pbkdf2_scoreboard sb = new();
	longint cycles;
	int     idle_pct;
	int     sent;

	pbkdf2_hmac_sha256_key_derive_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.data_byte(data_byte), .key_valid(key_valid), .key_byte(key_byte),
		.last(last), .overflow(overflow), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (arst_n && key_valid)
			sb.check_key(key_byte, last, overflow);
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_command(logic [1:0] md, logic [7:0] data);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start = 1'b1;
		mode = md;
		data_byte = data;
		do
			@(posedge clk);
		while (busy);
		sb.note_command(md, data);
		sent++;
	endtask

	// Waits for every key byte, then lets any load or keyless start finish.
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (sb.key_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] value);
		settle();
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (idx == REG_ITER)
			sb.iter_count = value;
		else
			sb.key_len = value[6:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic random_setting();
		int pick;
		pick = $urandom_range(6);
		write_reg(REG_ITER, 32'($urandom_range(3)));
		case (pick)
			0: write_reg(REG_KEYLEN, 32'd0);
			1: write_reg(REG_KEYLEN, 32'd1);
			2: write_reg(REG_KEYLEN, 32'd64);
			3: write_reg(REG_KEYLEN, 32'd127);
			4: write_reg(REG_KEYLEN, 32'd33);
			default: write_reg(REG_KEYLEN, 32'($urandom_range(1, 64)));
		endcase
	endtask

	// One password/salt load followed by a start, with occasional noise.
	task automatic derivation_sequence();
		int npw, nsalt;
		npw = ($urandom_range(99) < 8) ? $urandom_range(65, 131) : $urandom_range(16);
		nsalt = ($urandom_range(99) < 6) ? $urandom_range(118, 127) : $urandom_range(12);
		for (int i = 0; i < npw; i++)
			send_command(MODE_PW, 8'($urandom));
		if ($urandom_range(9) == 0)
			send_command(MODE_UNUSED, 8'($urandom));
		for (int i = 0; i < nsalt; i++)
			send_command(MODE_SALT, 8'($urandom));
		if ($urandom_range(9) == 0)
			send_command(2'($urandom), 8'($urandom));
		send_command(MODE_START, 8'($urandom));
	endtask

	initial begin
		int pcts[3];
		pcts = '{24, 76, 0};
		idle_pct = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Zero iterations act as one; a key length over 64 saturates, and zero derives nothing.
		write_reg(REG_ITER, 32'd0);
		write_reg(REG_KEYLEN, 32'd127);
		send_command(MODE_START, 8'hFF);
		write_reg(REG_KEYLEN, 32'd0);
		send_command(MODE_PW, 8'hA5);
		send_command(MODE_START, 8'h00);
		write_reg(REG_ITER, 32'd1);
		write_reg(REG_KEYLEN, 32'd1);
		send_command(MODE_PW, 8'h00);
		send_command(MODE_PW, 8'hFF);
		send_command(MODE_SALT, 8'hFF);
		send_command(MODE_SALT, 8'h00);
		send_command(MODE_UNUSED, 8'h5A);
		send_command(MODE_START, 8'h00);
		write_reg(REG_ITER, 32'd2);
		write_reg(REG_KEYLEN, 32'd64);
		send_command(MODE_SALT, 8'h01);
		send_command(MODE_START, 8'h00);
		write_reg(REG_ITER, 32'd3);
		write_reg(REG_KEYLEN, 32'd33);
		send_command(MODE_PW, 8'h7E);
		send_command(MODE_START, 8'h00);

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = pcts[ph];
			random_setting();
			while (sent < 20 + 65 * (ph + 1)) begin
				if ($urandom_range(3) == 0)
					random_setting();
				derivation_sequence();
			end
		end

		settle();
		$display("Sent %0d commands covering %0d derivations; %0d key bytes checked.",
			sent, sb.derivations, sb.checked);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
